>>> hdl/text_console_char_writer_defines.svh
// Assertion macros for the text console character writer.
// Taken by the top level; expects i_clk and i_rst_n in scope.
`ifndef TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH

// same-cycle implication
`define TCW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/tcw_pkg.sv
// Package for the text console character writer: geometry, character codes,
// cursor and write-request types, cell address helper. No dependencies.
`default_nettype none

package tcw_pkg;

    localparam int Columns  = 80;
    localparam int Rows     = 25;
    localparam int TabWidth = 8;
    localparam int Cells    = Rows * Columns;

    localparam int AddrW = $clog2(Cells);
    localparam int ColW  = $clog2(Columns + TabWidth);
    localparam int RowW  = $clog2(Rows + 1);
    localparam int IdxW  = 11;

    localparam logic [7:0] ChBackspace = 8'h08;
    localparam logic [7:0] ChTab       = 8'h09;
    localparam logic [7:0] ChNewline   = 8'h0A;
    localparam logic [7:0] ChReturn    = 8'h0D;
    localparam logic [7:0] ChSpace     = 8'h20;
    localparam logic [7:0] ChPrompt    = 8'h23;

    localparam logic [7:0] ResetTextAttr  = 8'h12;
    localparam logic [7:0] ResetBlankAttr = 8'h11;

    localparam logic CfgTextAttr  = 1'b0;
    localparam logic CfgBlankAttr = 1'b1;

    typedef struct packed {
        logic [ColW-1:0] col;
        logic [RowW-1:0] row;
        logic            wrapped;
        logic            need_scroll;
    } t_cur;

    typedef struct packed {
        logic             we;
        logic [AddrW-1:0] addr;
        logic [7:0]       chr;
    } t_wreq;

    function automatic logic [AddrW-1:0] cell_addr(input logic [RowW-1:0] row,
                                                   input logic [ColW-1:0] col);
        logic [AddrW-1:0] base;
        base = AddrW'(AddrW'(row) * AddrW'(Columns));
        return AddrW'(base + AddrW'(col));
    endfunction

endpackage

`default_nettype wire

>>> hdl/text_console_char_writer.sv
// A put or read word gives its result via StDone and the output register; the input stays
// stalled until then. A put that scrolls first copies 1920 cells up a row (one per cycle,
// reading and writing together), then blanks the 80 cells of the last row, with a prompt
// first unless wrapped. Reset: synchronous, active low; a clearing pass blanks every cell as
// input stalls. Configuration writes are taken in every cycle out of reset, the pass included.
// Top level: screen store, sequencer, output register. Depends on tcw_pkg, tcw_cursor, defines.
`default_nettype none
`include "text_console_char_writer_defines.svh"

module text_console_char_writer (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output      logic                      o_in_stall,
    input  wire logic                      i_command,
    input  wire logic [7:0]                i_char_code,
    input  wire logic [10:0]               i_read_index,
    output      logic                      o_out_valid,
    input  wire logic                      i_out_stall,
    output      logic [10:0]               o_cursor_index,
    output      logic [15:0]               o_cell_data,
    input  wire logic                      i_cfg_valid,
    output      logic                      o_cfg_ready,
    input  wire logic                      i_cfg_index,
    input  wire logic [7:0]                i_cfg_data
);

    localparam logic [2:0] StClear = 3'd0;
    localparam logic [2:0] StIdle  = 3'd1;
    localparam logic [2:0] StCopy  = 3'd2;
    localparam logic [2:0] StBlank = 3'd3;
    localparam logic [2:0] StDone  = 3'd4;

    localparam logic [tcw_pkg::AddrW-1:0] LastCell  = tcw_pkg::AddrW'(tcw_pkg::Cells - 1);
    localparam logic [tcw_pkg::AddrW-1:0] CopyLast  =
        tcw_pkg::AddrW'(tcw_pkg::Cells - tcw_pkg::Columns);
    localparam logic [tcw_pkg::AddrW-1:0] RowStride = tcw_pkg::AddrW'(tcw_pkg::Columns);

    logic [2:0]                r_state, n_state;
    logic [tcw_pkg::AddrW-1:0] r_cnt, n_cnt;
    logic [7:0]                r_text_attr, r_blank_attr;
    logic                      r_is_read, r_rd_ok;
    logic                      r_out_valid;
    logic [10:0]               r_cursor_index;
    logic [15:0]               r_cell_data;

    logic [15:0]               r_mem [tcw_pkg::Cells];
    logic [15:0]               r_mem_q;
    logic                      mem_we, mem_re;
    logic [tcw_pkg::AddrW-1:0] mem_waddr, mem_raddr;
    logic [15:0]               mem_wdata;

    logic                      in_accept, put_accept, read_ok, scroll_done, out_load;
    tcw_pkg::t_cur             cur;
    tcw_pkg::t_wreq            wreq;

    assign o_in_stall  = (r_state != StIdle);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign put_accept  = in_accept && !i_command;
    assign read_ok     = (i_read_index < 11'(tcw_pkg::Cells));
    assign o_cfg_ready = 1'b1;
    assign scroll_done = (r_state == StBlank) && (r_cnt == LastCell);
    assign out_load    = (r_state == StDone) && (!r_out_valid || !i_out_stall);

    tcw_cursor u_cursor (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_put         (put_accept),
        .i_char        (i_char_code),
        .i_scroll_done (scroll_done),
        .o_cur         (cur),
        .o_wreq        (wreq)
    );

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        mem_we    = 1'b0;
        mem_waddr = wreq.addr;
        mem_wdata = {r_text_attr, wreq.chr};
        mem_re    = 1'b0;
        mem_raddr = i_read_index[tcw_pkg::AddrW-1:0];
        case (r_state)
            StClear: begin
                mem_we    = 1'b1;
                mem_waddr = r_cnt;
                mem_wdata = {tcw_pkg::ResetBlankAttr, tcw_pkg::ChSpace};
                n_cnt     = tcw_pkg::AddrW'(r_cnt + 1'b1);
                if (r_cnt == LastCell) begin
                    n_state = StIdle;
                    n_cnt   = '0;
                end
            end
            StIdle: begin
                if (in_accept) begin
                    if (i_command) begin
                        mem_re  = read_ok;
                        n_state = StDone;
                    end else begin
                        mem_we  = wreq.we;
                        n_state = cur.need_scroll ? StCopy : StDone;
                        n_cnt   = '0;
                    end
                end
            end
            StCopy: begin
                mem_re    = (r_cnt != CopyLast);
                mem_raddr = tcw_pkg::AddrW'(r_cnt + RowStride);
                mem_we    = (r_cnt != '0);
                mem_waddr = tcw_pkg::AddrW'(r_cnt - 1'b1);
                mem_wdata = r_mem_q;
                if (r_cnt == CopyLast) begin
                    n_state = StBlank;
                end else begin
                    n_cnt = tcw_pkg::AddrW'(r_cnt + 1'b1);
                end
            end
            StBlank: begin
                mem_we    = 1'b1;
                mem_waddr = r_cnt;
                if (r_cnt == CopyLast && !cur.wrapped) begin
                    mem_wdata = {r_text_attr, tcw_pkg::ChPrompt};
                end else begin
                    mem_wdata = {r_blank_attr, tcw_pkg::ChSpace};
                end
                n_cnt = tcw_pkg::AddrW'(r_cnt + 1'b1);
                if (r_cnt == LastCell) begin
                    n_state = StDone;
                    n_cnt   = '0;
                end
            end
            StDone: begin
                if (out_load) begin
                    n_state = StIdle;
                end
            end
            default: begin
                n_state = StIdle;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_mem_q <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= StClear;
            r_cnt        <= '0;
            r_text_attr  <= tcw_pkg::ResetTextAttr;
            r_blank_attr <= tcw_pkg::ResetBlankAttr;
            r_out_valid  <= 1'b0;
            r_is_read    <= 1'b0;
            r_rd_ok      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == tcw_pkg::CfgTextAttr) begin
                    r_text_attr <= i_cfg_data;
                end else begin
                    r_blank_attr <= i_cfg_data;
                end
            end
            if (in_accept) begin
                r_is_read <= i_command;
                r_rd_ok   <= read_ok;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_cursor_index <= 11'(tcw_pkg::cell_addr(cur.row, cur.col));
            r_cell_data    <= (r_is_read && r_rd_ok) ? r_mem_q : 16'h0000;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_cursor_index = r_cursor_index;
    assign o_cell_data    = r_cell_data;

    `TCW_ASSERT_NOW(a_busy_stalls, (r_state != StIdle), o_in_stall, "input taken while busy")
    `TCW_ASSERT_NOW(a_row_in_range, (r_state == StIdle),
                    (cur.row < tcw_pkg::RowW'(tcw_pkg::Rows)), "cursor row past screen")
    `TCW_ASSERT_NOW(a_write_in_range, mem_we, (mem_waddr <= LastCell), "write beyond store")
    `TCW_ASSERT_NEXT(a_accept_to_work, in_accept,
                     (r_state == StDone || r_state == StCopy), "accepted word lost")

endmodule

`default_nettype wire

>>> hdl/tcw_cursor.sv
// Cursor unit: column, row and wrap flag, next position for a put word and
// the matching cell write request. Depends on tcw_pkg.
`default_nettype none

module tcw_cursor (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_put,
    input  wire logic [7:0]           i_char,
    input  wire logic                 i_scroll_done,
    output tcw_pkg::t_cur             o_cur,
    output tcw_pkg::t_wreq            o_wreq
);

    logic [tcw_pkg::ColW-1:0] r_col, n_col;
    logic [tcw_pkg::RowW-1:0] r_row, n_row;
    logic                     r_wrapped, n_wrapped;
    logic [tcw_pkg::RowW-1:0] row_inc;

    assign row_inc = tcw_pkg::RowW'(r_row + 1'b1);

    always_comb begin
        n_col       = r_col;
        n_row       = r_row;
        n_wrapped   = r_wrapped;
        o_wreq.we   = 1'b0;
        o_wreq.addr = tcw_pkg::cell_addr(r_row, r_col);
        o_wreq.chr  = i_char;
        case (i_char)
            tcw_pkg::ChBackspace: begin
                if (r_col != '0) begin
                    n_col = tcw_pkg::ColW'(r_col - 1'b1);
                end
            end
            tcw_pkg::ChTab: begin
                n_col = tcw_pkg::ColW'(((r_col / tcw_pkg::TabWidth) + 1) * tcw_pkg::TabWidth);
            end
            tcw_pkg::ChReturn: begin
                n_col = '0;
            end
            tcw_pkg::ChNewline: begin
                n_wrapped   = 1'b0;
                n_row       = row_inc;
                n_col       = tcw_pkg::ColW'(1);
                o_wreq.we   = (row_inc < tcw_pkg::RowW'(tcw_pkg::Rows));
                o_wreq.addr = tcw_pkg::cell_addr(row_inc, '0);
                o_wreq.chr  = tcw_pkg::ChPrompt;
            end
            default: begin
                if (i_char >= tcw_pkg::ChSpace) begin
                    o_wreq.we = 1'b1;
                    n_col     = tcw_pkg::ColW'(r_col + 1'b1);
                end
            end
        endcase
        if (n_col >= tcw_pkg::ColW'(tcw_pkg::Columns)) begin
            n_wrapped = 1'b1;
            n_col     = '0;
            n_row     = tcw_pkg::RowW'(n_row + 1'b1);
        end
        if (n_col == '0) begin
            n_col = tcw_pkg::ColW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_wrapped <= 1'b0;
        end else if (i_scroll_done) begin
            r_row <= tcw_pkg::RowW'(tcw_pkg::Rows - 1);
            r_col <= tcw_pkg::ColW'(1);
        end else if (i_put) begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_wrapped <= n_wrapped;
        end
    end

    assign o_cur.col         = r_col;
    assign o_cur.row         = r_row;
    assign o_cur.wrapped     = r_wrapped;
    assign o_cur.need_scroll = (n_row == tcw_pkg::RowW'(tcw_pkg::Rows));

endmodule

`default_nettype wire

>>> dv/tcw_check_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the text console character writer: keeps its own screen, cursor and
// attribute registers and checks every output word in order. Depends on tcw_pkg.
package tcw_check_pkg;
    import tcw_pkg::*;

    localparam logic CmdPut  = 1'b0;
    localparam logic CmdRead = 1'b1;

    typedef struct packed {
        logic [10:0] cursor_index;
        logic [15:0] cell_data;
    } t_console_word;

    class console_scoreboard;
        logic [15:0]   screen [Cells];
        logic [6:0]    column;
        logic [4:0]    row;
        logic          wrapped;
        logic [7:0]    text_attr;
        logic [7:0]    blank_attr;
        t_console_word expected_words [$];
        int            mismatches;
        int            words_checked;
        int            items_noted;
        int            reads_noted;
        int            scrolls;
        int            wrap_scrolls;

        function new();
            text_attr  = ResetTextAttr;
            blank_attr = ResetBlankAttr;
            foreach (screen[i]) screen[i] = {blank_attr, ChSpace};
            column        = '0;
            row           = '0;
            wrapped       = 1'b0;
            mismatches    = 0;
            words_checked = 0;
            items_noted   = 0;
            reads_noted   = 0;
            scrolls       = 0;
            wrap_scrolls  = 0;
        endfunction

        function void set_register(input logic idx, input logic [7:0] data);
            if (idx == CfgTextAttr) begin
                text_attr = data;
            end else begin
                blank_attr = data;
            end
        endfunction

        function logic [10:0] cursor_index();
            return 11'(row * Columns + column);
        endfunction

        function int outstanding();
            return expected_words.size();
        endfunction

        function void store_char(input logic [4:0] r, input logic [6:0] c,
                                 input logic [7:0] ch);
            if (r < Rows && c < Columns) begin
                screen[r * Columns + c] = {text_attr, ch};
            end
        endfunction

        function void scroll_up();
            for (int i = 0; i < Cells - Columns; i++) screen[i] = screen[i + Columns];
            for (int i = Cells - Columns; i < Cells; i++) screen[i] = {blank_attr, ChSpace};
            row = 5'(Rows - 1);
            scrolls++;
            if (!wrapped) begin
                store_char(row, 7'd0, ChPrompt);
                column = 7'd1;
            end else begin
                wrap_scrolls++;
            end
        endfunction

        function void apply_put(input logic [7:0] ch);
            if (ch == ChBackspace) begin
                if (column != 0) column = column - 7'd1;
            end else if (ch == ChTab) begin
                column = 7'((column / TabWidth + 1) * TabWidth);
            end else if (ch == ChReturn) begin
                column = '0;
            end else if (ch == ChNewline) begin
                wrapped = 1'b0;
                row     = row + 5'd1;
                store_char(row, 7'd0, ChPrompt);
                column  = 7'd1;
            end else if (ch >= ChSpace) begin
                store_char(row, column, ch);
                column = column + 7'd1;
            end
            if (column >= Columns) begin
                wrapped = 1'b1;
                column  = '0;
                row     = row + 5'd1;
            end
            if (column == 0) column = 7'd1;
            if (row >= Rows) scroll_up();
        endfunction

        function void note_input(input logic cmd, input logic [7:0] ch,
                                 input logic [10:0] idx);
            t_console_word w;
            w.cell_data = '0;
            items_noted++;
            if (cmd == CmdPut) begin
                apply_put(ch);
            end else begin
                reads_noted++;
                if (idx < Cells) w.cell_data = screen[idx];
            end
            w.cursor_index = cursor_index();
            expected_words.push_back(w);
        endfunction

        function void check_result(input logic [10:0] cursor, input logic [15:0] cell_word);
            t_console_word want;
            words_checked++;
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: cursor %0d cell %h", cursor, cell_word);
                return;
            end
            want = expected_words.pop_front();
            if (want.cursor_index !== cursor || want.cell_data !== cell_word) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("word %0d: cursor exp %0d got %0d, cell exp %h got %h",
                             words_checked, want.cursor_index, cursor, want.cell_data,
                             cell_word);
            end
        endfunction
    endclass

endpackage

>>> dv/tb.sv
`timescale 1ns / 100ps
// Testbench top for text_console_char_writer: directed and random put/read words under
// varying back-pressure and attribute settings. Depends on tcw_pkg and tcw_check_pkg.
module tb;
    import tcw_pkg::*;
    import tcw_check_pkg::*;

    localparam int CycleLimit = 12_000_000;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_stall;
    logic        i_command      = CmdPut;
    logic [7:0]  i_char_code    = '0;
    logic [10:0] i_read_index   = '0;
    logic        o_out_valid;
    logic        i_out_stall    = 1'b0;
    logic [10:0] o_cursor_index;
    logic [15:0] o_cell_data;
    logic        i_cfg_valid    = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index    = CfgTextAttr;
    logic [7:0]  i_cfg_data     = '0;

    int in_idle_pct   = 0;
    int out_stall_pct = 0;
    int hold_cycles   = 0;
    int cycle_count   = 0;

    console_scoreboard sb = new();

    text_console_char_writer uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_char_code    (i_char_code),
        .i_read_index   (i_read_index),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_cursor_index (o_cursor_index),
        .o_cell_data    (o_cell_data),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CycleLimit) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("** text_console_char_writer: FAILED **");
        $finish;
    end

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_stall <= 1'b1;
            hold_cycles--;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_cursor_index, o_cell_data);
    end

    task automatic send_word(input logic cmd, input logic [7:0] ch, input logic [10:0] idx);
        @(negedge i_clk);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_char_code  <= ch;
        i_read_index <= idx;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(cmd, ch, idx);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(input logic idx, input logic [7:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_register(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_run(input int count);
        logic        cmd;
        logic [7:0]  ch;
        logic [10:0] idx;
        int          burst;
        int          sel;
        int          pos;
        int          off;
        burst = 0;
        for (int n = 0; n < count; n++) begin
            cmd = CmdPut;
            ch  = 8'($urandom_range(255, 32));
            idx = 11'($urandom_range(2047));
            sel = $urandom_range(199);
            if (burst > 0) begin
                burst--;
                if ($urandom_range(15) == 0) ch = ChTab;
            end else if (sel == 0) begin
                burst = $urandom_range(100, 20);
            end else if (sel <= 28) begin
                cmd = CmdRead;
                ch  = 8'($urandom_range(255));
                if ($urandom_range(1) == 0) begin
                    pos = sb.cursor_index();
                    off = $urandom_range(160);
                    idx = 11'((pos > off) ? pos - off : 0);
                end
            end else if (sel <= 36) begin
                ch = ChNewline;
            end else if (sel <= 44) begin
                ch = ChTab;
            end else if (sel <= 52) begin
                ch = ChBackspace;
            end else if (sel <= 58) begin
                ch = ChReturn;
            end else if (sel <= 64) begin
                ch = 8'($urandom_range(31));
            end
            send_word(cmd, ch, idx);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        in_idle_pct   = 22;
        out_stall_pct = 68;
        send_word(CmdRead, 8'h00, 11'd0);
        send_word(CmdRead, 8'hFF, 11'd1999);
        send_word(CmdRead, 8'h00, 11'd2000);
        send_word(CmdRead, 8'hFF, 11'd2047);
        send_word(CmdPut, ChBackspace, 11'd2047);
        send_word(CmdPut, 8'h00, 11'd0);
        send_word(CmdPut, 8'h1F, 11'd0);
        send_word(CmdPut, 8'h41, 11'd0);
        send_word(CmdPut, 8'hFF, 11'd0);
        send_word(CmdPut, ChSpace, 11'd0);
        send_word(CmdPut, 8'h7F, 11'd0);
        send_word(CmdPut, ChTab, 11'd0);
        send_word(CmdPut, ChReturn, 11'd0);
        send_word(CmdPut, ChNewline, 11'd0);
        send_word(CmdRead, 8'h00, 11'd80);
        send_word(CmdRead, 8'h00, 11'd1);
        for (int n = 0; n < 10; n++) send_word(CmdPut, ChTab, 11'd0);
        send_word(CmdRead, 8'h00, 11'd160);
        wait_drained();

        write_register(CfgTextAttr, 8'hFF);
        write_register(CfgBlankAttr, 8'h00);
        random_run(600);
        wait_drained();

        in_idle_pct   = 68;
        out_stall_pct = 22;
        write_register(CfgTextAttr, 8'h00);
        write_register(CfgBlankAttr, 8'hFF);
        random_run(600);
        wait_drained();

        in_idle_pct   = 0;
        out_stall_pct = 0;
        write_register(CfgTextAttr, 8'($urandom_range(255)));
        write_register(CfgBlankAttr, 8'($urandom_range(255)));
        hold_cycles = 400;
        random_run(300);
        wait_drained();
        random_run(300);
        wait_drained();
        repeat (10) @(posedge i_clk);

        $display("Run covered %0d items (%0d reads) and %0d result words, with %0d scrolls",
                 sb.items_noted, sb.reads_noted, sb.words_checked, sb.scrolls);
        $display("(%0d of them after a line wrap) across four attribute settings.",
                 sb.wrap_scrolls);
        if (sb.mismatches == 0) begin
            $display("** text_console_char_writer: PASSED **");
        end else begin
            $display("%0d mismatching words", sb.mismatches);
            $display("** text_console_char_writer: FAILED **");
        end
        $finish;
    end

endmodule
